@@ design/bbip_pkg.sv @@
`timescale 1ns / 1ps
// Package for the beacon bearing incremental PID core: widths, register
// indexes, FSM type and the detector weight table. No dependencies.
package bbip_pkg;

    localparam int DET_CNT   = 10;
    localparam int DET_IDX_W = $clog2(DET_CNT);
    localparam int GAIN_W    = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int SUM_W     = 10;   // -223..275
    localparam int MAG_W     = 9;    // magnitude of the weight sum
    localparam int CNT_W     = 4;    // active detectors 0..10
    localparam int REM_W     = 5;    // divider remainder, shifted
    localparam int ERR_W     = 8;
    localparam int OP_W      = 11;   // second-difference operand
    localparam int PROD_W    = GAIN_W + OP_W;
    localparam int DELTA_W   = 25;
    localparam int ACC_W     = 32;
    localparam int DEG_W     = ACC_W - 8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_MIN      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_MAX      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_TICKS = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CRUISE_SPEED = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_SPEED = 3'd7;

    // input kind and output mode codes
    localparam logic       KIND_FRAME = 1'b0;
    localparam logic       KIND_TICK  = 1'b1;
    localparam logic [1:0] MODE_TRACK    = 2'd0;
    localparam logic [1:0] MODE_STRAIGHT = 2'd1;
    localparam logic [1:0] MODE_SEARCH   = 2'd2;

    localparam logic [7:0] SERVO_CENTER = 8'd90;
    localparam logic [7:0] SERVO_SEARCH = 8'd45;
    localparam logic [7:0] SERVO_MAX    = 8'd180;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SUM  = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_ACC  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    // bearing weight of each detector, left to right
    function automatic logic signed [ERR_W-1:0] det_weight(input logic [DET_IDX_W-1:0] idx);
        logic signed [ERR_W-1:0] w;
        case (idx)
            4'd0:    w = -8'sd88;
            4'd1:    w = -8'sd65;
            4'd2:    w = -8'sd45;
            4'd3:    w = -8'sd25;
            4'd4:    w = 8'sd10;
            4'd5:    w = 8'sd15;
            4'd6:    w = 8'sd35;
            4'd7:    w = 8'sd55;
            4'd8:    w = 8'sd75;
            4'd9:    w = 8'sd85;
            default: w = 8'sd0;
        endcase
        return w;
    endfunction

endpackage

@@ design/beacon_bearing_incremental_pid_core.sv @@
`timescale 1ns / 1ps
// Top level of the beacon bearing incremental PID steering core.
// Depends on bbip_pkg; the port checker bbip_checker binds to it.
//
// A detector frame in which a beacon is seen passes through a scan of the ten
// detectors, one per cycle, nine steps of the bit-serial divider that forms
// the bearing, three passes through the single shared 12x11 multiplier for
// the P, I and D terms, one saturating accumulate and one output step.
// s_axis_tready is high only while the core is idle; the output register
// lets the next word in while a command still waits on m_axis.
module beacon_bearing_incremental_pid_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // [9:0] detectors
    input  logic [0:0]                     s_axis_tuser,  // [0] kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // [7:0] servo_angle,
                                                          // [15:8] motor_speed,
                                                          // [23:16] bearing
    output logic [1:0]                     m_axis_tuser,  // [1:0] mode
    input  logic                           i_cfg_we,
    input  logic [bbip_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bbip_pkg::CFG_W-1:0]     i_cfg_data
);
    import bbip_pkg::*;

    localparam logic [CNT_W-1:0] LAST_DET = CNT_W'(DET_CNT - 1);
    localparam logic [CNT_W-1:0] LAST_DIV = CNT_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] LAST_MUL = CNT_W'(2);

    // configuration registers
    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic signed [7:0]        r_out_min, r_out_max;
    logic [7:0]               r_search_ticks, r_cruise_speed, r_search_speed;

    // controller state
    logic signed [ERR_W-1:0]  r_last_err, r_older_err;
    logic signed [ACC_W-1:0]  r_acc;
    logic [7:0]               r_tick_cnt;
    logic                     r_straight_done;

    // sequencer and datapath
    t_state                   r_state;
    logic [CNT_W-1:0]         r_step;
    logic [DET_CNT-1:0]       r_det;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_divisor;
    logic [REM_W-1:0]         r_rem;
    logic [MAG_W-1:0]         r_quo;
    logic                     r_neg;
    logic signed [ERR_W-1:0]  r_e0;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DELTA_W-1:0] r_delta;
    logic [1:0]               r_mode;

    // output register
    logic                     r_m_valid;
    logic [23:0]              r_m_data;
    logic [1:0]               r_m_user;

    logic                     w_in_acc;
    logic                     w_out_load;
    logic                     w_active;
    logic signed [SUM_W-1:0]  w_sum_nx;
    logic [CNT_W-1:0]         w_cnt_nx;
    logic [MAG_W-1:0]         w_mag;
    logic [REM_W-1:0]         w_rem_sh;
    logic                     w_q_bit;
    logic [REM_W-1:0]         w_rem_nx;
    logic [MAG_W-1:0]         w_quo_nx;
    logic signed [MAG_W:0]    w_quo_signed;
    logic signed [GAIN_W-1:0] w_mul_a;
    logic signed [OP_W-1:0]   w_mul_b;
    logic signed [OP_W-1:0]   w_e0x, w_e1x, w_e2x;
    logic signed [DELTA_W-1:0] w_delta_fin;
    logic signed [ACC_W:0]    w_acc_sum;
    logic signed [ACC_W-1:0]  w_acc_sat;
    logic signed [DEG_W-1:0]  w_deg, w_deg_hi, w_deg_lo;
    logic signed [9:0]        w_servo_raw;
    logic [7:0]               w_servo;
    logic [23:0]              w_pay_data;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // detector scan: one detector per cycle
    assign w_active = !r_det[r_step];
    always_comb begin
        w_sum_nx = r_sum;
        w_cnt_nx = r_cnt;
        if (w_active) begin
            w_sum_nx = r_sum + SUM_W'(det_weight(r_step[DET_IDX_W-1:0]));
            w_cnt_nx = r_cnt + CNT_W'(1);
        end
    end
    assign w_mag = w_sum_nx[SUM_W-1] ? MAG_W'(-w_sum_nx) : MAG_W'(w_sum_nx);

    // restoring divider, one quotient bit per step
    assign w_rem_sh     = {r_rem[REM_W-2:0], r_quo[MAG_W-1]};
    assign w_q_bit      = (w_rem_sh >= REM_W'(r_divisor));
    assign w_rem_nx     = w_q_bit ? (w_rem_sh - REM_W'(r_divisor)) : w_rem_sh;
    assign w_quo_nx     = {r_quo[MAG_W-2:0], w_q_bit};
    assign w_quo_signed = r_neg ? -$signed({1'b0, w_quo_nx}) : $signed({1'b0, w_quo_nx});

    // shared multiplier operand select
    assign w_e0x = OP_W'(r_e0);
    assign w_e1x = OP_W'(r_last_err);
    assign w_e2x = OP_W'(r_older_err);
    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                w_mul_a = r_gain_p;
                w_mul_b = w_e0x - w_e1x;
            end
            2'd1: begin
                w_mul_a = r_gain_i;
                w_mul_b = w_e0x;
            end
            2'd2: begin
                w_mul_a = r_gain_d;
                w_mul_b = w_e0x - (w_e1x <<< 1) + w_e2x;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // saturating accumulate
    assign w_delta_fin = r_delta + DELTA_W'(r_prod);
    assign w_acc_sum   = (ACC_W+1)'(r_acc) + (ACC_W+1)'(w_delta_fin);
    always_comb begin
        if (w_acc_sum[ACC_W] != w_acc_sum[ACC_W-1]) begin
            w_acc_sat = w_acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                         : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            w_acc_sat = w_acc_sum[ACC_W-1:0];
        end
    end

    // degrees, clamp to out_max then out_min, then servo range
    assign w_deg = r_acc[ACC_W-1:8];
    always_comb begin
        w_deg_hi = (w_deg > DEG_W'(r_out_max)) ? DEG_W'(r_out_max) : w_deg;
        w_deg_lo = (w_deg_hi < DEG_W'(r_out_min)) ? DEG_W'(r_out_min) : w_deg_hi;
        w_servo_raw = 10'(w_deg_lo) + 10'sd90;
        if (w_servo_raw < 10'sd0) begin
            w_servo = 8'd0;
        end else if (w_servo_raw > 10'sd180) begin
            w_servo = SERVO_MAX;
        end else begin
            w_servo = w_servo_raw[7:0];
        end
    end

    always_comb begin
        case (r_mode)
            MODE_TRACK:    w_pay_data = {r_last_err, r_cruise_speed, w_servo};
            MODE_STRAIGHT: w_pay_data = {8'd0, r_cruise_speed, SERVO_CENTER};
            MODE_SEARCH:   w_pay_data = {8'd0, r_search_speed, SERVO_SEARCH};
            default:       w_pay_data = '0;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p       <= 12'sd384;
            r_gain_i       <= 12'sd0;
            r_gain_d       <= 12'sd77;
            r_out_min      <= -8'sd60;
            r_out_max      <= 8'sd60;
            r_search_ticks <= 8'd3;
            r_cruise_speed <= 8'd255;
            r_search_speed <= 8'd127;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_GAIN_P:       r_gain_p       <= i_cfg_data;
                REG_GAIN_I:       r_gain_i       <= i_cfg_data;
                REG_GAIN_D:       r_gain_d       <= i_cfg_data;
                REG_OUT_MIN:      r_out_min      <= i_cfg_data[7:0];
                REG_OUT_MAX:      r_out_max      <= i_cfg_data[7:0];
                REG_SEARCH_TICKS: r_search_ticks <= i_cfg_data[7:0];
                REG_CRUISE_SPEED: r_cruise_speed <= i_cfg_data[7:0];
                REG_SEARCH_SPEED: r_search_speed <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_step          <= '0;
            r_last_err      <= '0;
            r_older_err     <= '0;
            r_acc           <= '0;
            r_tick_cnt      <= '0;
            r_straight_done <= 1'b0;
            r_mode          <= MODE_TRACK;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (s_axis_tuser[0] == KIND_TICK) begin
                            if (r_tick_cnt != 8'd255) begin
                                r_tick_cnt <= r_tick_cnt + 8'd1;
                            end
                        end else begin
                            r_det   <= s_axis_tdata[DET_CNT-1:0];
                            r_sum   <= '0;
                            r_cnt   <= '0;
                            r_step  <= '0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    r_sum  <= w_sum_nx;
                    r_cnt  <= w_cnt_nx;
                    r_step <= r_step + CNT_W'(1);
                    if (r_step == LAST_DET) begin
                        r_step <= '0;
                        if (w_cnt_nx != '0) begin
                            r_rem     <= '0;
                            r_quo     <= w_mag;
                            r_neg     <= w_sum_nx[SUM_W-1];
                            r_divisor <= w_cnt_nx + CNT_W'(1);
                            r_state   <= S_DIV;
                        end else if (r_tick_cnt >= r_search_ticks) begin
                            r_tick_cnt <= '0;
                            r_mode     <= r_straight_done ? MODE_SEARCH : MODE_STRAIGHT;
                            r_straight_done <= 1'b1;
                            r_state    <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= w_rem_nx;
                    r_quo  <= w_quo_nx;
                    r_step <= r_step + CNT_W'(1);
                    if (r_step == LAST_DIV) begin
                        r_step  <= '0;
                        r_e0    <= w_quo_signed[ERR_W-1:0];
                        r_prod  <= '0;
                        r_delta <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_mul_a * w_mul_b;
                    r_delta <= r_delta + DELTA_W'(r_prod);
                    r_step  <= r_step + CNT_W'(1);
                    if (r_step == LAST_MUL) begin
                        r_step  <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc       <= w_acc_sat;
                    r_older_err <= r_last_err;
                    r_last_err  <= r_e0;
                    r_tick_cnt  <= '0;
                    r_mode      <= MODE_TRACK;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= w_pay_data;
            r_m_user <= r_mode;
        end
    end

endmodule

@@ design/bbip_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the beacon bearing incremental PID core, bound to
// the top level below. Depends on bbip_pkg.
module bbip_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [15:0]                    s_axis_tdata,
    input logic [0:0]                     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [23:0]                    m_axis_tdata,
    input logic [1:0]                     m_axis_tuser,
    input logic                           i_cfg_we,
    input logic [bbip_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input logic [bbip_pkg::CFG_W-1:0]     i_cfg_data
);
    import bbip_pkg::*;

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // a word is never shown in the cycle after its accept
    a_no_quick_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("output appeared right after accept");

    // straight and search commands carry fixed angles and no bearing
    a_fixed_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == MODE_STRAIGHT || m_axis_tuser == MODE_SEARCH)
            |-> m_axis_tdata[23:16] == 8'd0
                && ((m_axis_tuser == MODE_STRAIGHT && m_axis_tdata[7:0] == SERVO_CENTER)
                    || (m_axis_tuser == MODE_SEARCH && m_axis_tdata[7:0] == SERVO_SEARCH)))
        else $error("bad straight or search command");

    // servo stays in range and mode is a used code
    a_servo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:0] <= SERVO_MAX
            && (m_axis_tuser == MODE_TRACK || m_axis_tuser == MODE_STRAIGHT
                || m_axis_tuser == MODE_SEARCH))
        else $error("servo angle or mode out of range");

endmodule

bind beacon_bearing_incremental_pid_core bbip_checker u_bbip_checker (.*);
